// ===== hdl/rsbts_pkg.sv =====
// ----------------------------------------------------------------------------
// rsbts_pkg
// Shared constants, types and arithmetic helpers for the record sorter.
// ----------------------------------------------------------------------------
package rsbts_pkg;

   // Capacity and course configuration.
   localparam int MAX_RECORDS  = 64;
   localparam int COURSES      = 4;
   localparam int SCORE_FIELDS = 4;
   localparam int USED_SCORES  = (COURSES > SCORE_FIELDS) ? SCORE_FIELDS : COURSES;
   localparam int DIVISOR      = (COURSES < 1) ? 1 : COURSES;

   // Field widths.
   localparam int ID_W    = 32;
   localparam int SCORE_W = 11;
   localparam int TOTAL_W = 13;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = $clog2(MAX_RECORDS + 1);

   // One stored record as it sits in a sorter cell.
   typedef struct packed {
      logic               valid;
      logic [ID_W-1:0]    id;
      logic [INDEX_W-1:0] idx;
      logic [TOTAL_W-1:0] total;
   } entry_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

   // Controller states.
   typedef enum logic {
      ST_FILL,
      ST_EMIT
   } state_type;

   // Sum of the scores that take part in the total.
   function automatic logic [TOTAL_W-1:0] total_of(
      input logic [SCORE_W-1:0] a,
      input logic [SCORE_W-1:0] b,
      input logic [SCORE_W-1:0] c,
      input logic [SCORE_W-1:0] d
   );
      logic [TOTAL_W-1:0] sum;
      sum = '0;
      if (USED_SCORES > 0) sum = sum + TOTAL_W'(a);
      if (USED_SCORES > 1) sum = sum + TOTAL_W'(b);
      if (USED_SCORES > 2) sum = sum + TOTAL_W'(c);
      if (USED_SCORES > 3) sum = sum + TOTAL_W'(d);
      return sum;
   endfunction

   // Average with 2 fractional bits: total * 4 / DIVISOR, truncated.
   function automatic logic [TOTAL_W-1:0] average_of(input logic [TOTAL_W-1:0] total);
      logic [TOTAL_W+1:0] scaled;
      scaled = {total, 2'b00};
      return TOTAL_W'(scaled / DIVISOR);
   endfunction

endpackage

// ===== hdl/rsbts_if.sv =====
// ----------------------------------------------------------------------------
// rsbts request and response channels
// Valid/ready channels carrying one student record in and one ranked record out.
// ----------------------------------------------------------------------------
interface rsbts_req_if;
   import rsbts_pkg::*;

   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    student_id;
   logic [SCORE_W-1:0] score_a;
   logic [SCORE_W-1:0] score_b;
   logic [SCORE_W-1:0] score_c;
   logic [SCORE_W-1:0] score_d;
   logic               final_record;

   modport source (
      output valid, student_id, score_a, score_b, score_c, score_d, final_record,
      input  ready
   );
   modport sink (
      input  valid, student_id, score_a, score_b, score_c, score_d, final_record,
      output ready
   );
endinterface

interface rsbts_rsp_if;
   import rsbts_pkg::*;

   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    out_id;
   logic [INDEX_W-1:0] arrival_index;
   logic [TOTAL_W-1:0] total_score;
   logic [TOTAL_W-1:0] average_score;
   logic               dropped_flag;
   logic               last_out;

   modport source (
      output valid, out_id, arrival_index, total_score, average_score, dropped_flag,
             last_out,
      input  ready
   );
   modport sink (
      input  valid, out_id, arrival_index, total_score, average_score, dropped_flag,
             last_out,
      output ready
   );
endinterface

// ===== hdl/rsbts_cell.sv =====
// ----------------------------------------------------------------------------
// rsbts_cell
// One slot of the insertion chain: holds a record, makes room for a new one
// by taking its upper neighbor, and shifts toward the head during emission.
// ----------------------------------------------------------------------------
module rsbts_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  rsbts_pkg::cell_ctrl_type ctrl,
   input  rsbts_pkg::entry_type     new_entry,
   input  rsbts_pkg::entry_type     prev_entry,
   input  logic                     prev_lt,
   input  rsbts_pkg::entry_type     next_entry,
   output rsbts_pkg::entry_type     entry,
   output logic                     lt
);
   import rsbts_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // The new record belongs at or above this slot when the slot is empty or
   // holds a strictly smaller total; equal totals stay ahead, keeping order.
   assign lt = !entry_ff.valid || (entry_ff.total < new_entry.total);

   // Next content of the slot.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = next_entry;
      end else if (ctrl.insert && lt) begin
         if (prev_lt) begin
            entry_in = prev_entry;
         end else begin
            entry_in = new_entry;
         end
      end
   end

   // Slot register: only the occupancy flag is reset, the payload just follows.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.id    <= entry_in.id;
      entry_ff.idx   <= entry_in.idx;
      entry_ff.total <= entry_in.total;
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/rsbts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsbts_ctrl
// Fill/emit sequencer: counts stored records, tracks overflow and drives the
// insert and pop commands of the cell chain.
// ----------------------------------------------------------------------------
module rsbts_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_final,
   input  logic                            rsp_ready,
   output logic                            req_ready,
   output logic                            rsp_valid,
   output logic                            last_out,
   output logic                            dropped,
   output logic [rsbts_pkg::INDEX_W-1:0]   arrival_index,
   output rsbts_pkg::cell_ctrl_type        cell_ctrl
);
   import rsbts_pkg::*;

   state_type           state_ff;
   state_type           state_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic                overflow_ff;
   logic                overflow_in;
   logic                req_fire;
   logic                rsp_fire;
   logic                has_room;

   assign has_room = (count_ff < COUNT_W'(MAX_RECORDS));
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_fire && req_final) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire && last_out) state_in = ST_FILL;
         end
         default: state_in = ST_FILL;
      endcase
   end

   // Outputs decoded from the state.
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_FILL: req_ready = 1'b1;
         ST_EMIT: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign last_out         = (count_ff == COUNT_W'(1));
   assign dropped          = overflow_ff;
   assign arrival_index    = INDEX_W'(count_ff);
   assign cell_ctrl.insert = req_fire && has_room;
   assign cell_ctrl.pop    = rsp_fire;

   // Record count and overflow tracking.
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (req_fire) begin
         if (has_room) begin
            count_in = count_ff + COUNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end else if (rsp_fire) begin
         count_in = count_ff - COUNT_W'(1);
         if (last_out) overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_FILL;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // The count never exceeds the chain length.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_RECORDS))
      else $error("rsbts_ctrl: record count above capacity");

   // Emission only runs while records are stored.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != '0))
      else $error("rsbts_ctrl: response offered with empty store");

   // Taking the last response empties the block and clears overflow.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && last_out) |=> (count_ff == '0) && !overflow_ff && req_ready)
      else $error("rsbts_ctrl: block not cleared after last response");

   // A request never lands while emitting.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("rsbts_ctrl: fill and emit overlap");

endmodule

// ===== hdl/record_sort_by_total_score.sv =====
// ----------------------------------------------------------------------------
// record_sort_by_total_score
// Stable descending sort of student records by total score, built as an
// insertion chain of cells that keeps the records in rank order as they arrive.
// ----------------------------------------------------------------------------
//   channel | dir | handshake            | payload
//   req     | in  | req_chan.valid/ready | student_id, score_a..d, final_record
//   rsp     | out | rsp_chan.valid/ready | out_id, arrival_index, total_score,
//           |     |                      | average_score, dropped_flag, last_out
//
// A record is placed in its rank in the cycle it is accepted, so records stream
// in at one per cycle. After the final record the chain shifts toward its head,
// giving one response per cycle while rsp_chan.ready is high; no request is
// taken during that emission. Reset is synchronous and empties the chain.
// A stalled response holds the head cell; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module record_sort_by_total_score (
   input  logic  clock,
   input  logic  reset,
   rsbts_req_if.sink   req_chan,
   rsbts_rsp_if.source rsp_chan
);
   import rsbts_pkg::*;

   entry_type     new_entry;
   entry_type     cell_entry [MAX_RECORDS];
   logic          cell_lt    [MAX_RECORDS];
   cell_ctrl_type cell_ctrl;
   logic [INDEX_W-1:0] arrival_index;
   logic          req_ready;
   logic          rsp_valid;
   logic          last_out;
   logic          dropped;

   // Sequencer.
   rsbts_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_final     (req_chan.final_record),
      .rsp_ready     (rsp_chan.ready),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .last_out      (last_out),
      .dropped       (dropped),
      .arrival_index (arrival_index),
      .cell_ctrl     (cell_ctrl)
   );

   // Record formed from the incoming request.
   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.id    = req_chan.student_id;
      new_entry.idx   = arrival_index;
      new_entry.total = total_of(req_chan.score_a, req_chan.score_b,
                                 req_chan.score_c, req_chan.score_d);
   end

   // Insertion chain, highest total at cell zero.
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;
      logic      prev_lt;

      if (i == 0) begin : g_head
         assign prev_entry = new_entry;
         assign prev_lt    = 1'b0;
      end else begin : g_body
         assign prev_entry = cell_entry[i-1];
         assign prev_lt    = cell_lt[i-1];
      end

      if (i == MAX_RECORDS - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      rsbts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .new_entry  (new_entry),
         .prev_entry (prev_entry),
         .prev_lt    (prev_lt),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .lt         (cell_lt[i])
      );
   end

   // Channel outputs come straight from the head cell and the sequencer.
   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.out_id        = cell_entry[0].id;
   assign rsp_chan.arrival_index = cell_entry[0].idx;
   assign rsp_chan.total_score   = cell_entry[0].total;
   assign rsp_chan.average_score = average_of(cell_entry[0].total);
   assign rsp_chan.dropped_flag  = dropped;
   assign rsp_chan.last_out      = last_out;

   // The head cell always holds a record while responses are offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cell_entry[0].valid)
      else $error("record_sort_by_total_score: empty head during emission");

   // Responses leave in non-increasing order of total.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chan.ready && !last_out) |=>
         (cell_entry[0].total <= $past(cell_entry[0].total)))
      else $error("record_sort_by_total_score: response order broken");

   // The two leading cells are always in rank order.
   assert property (@(posedge clock) disable iff (reset)
      cell_entry[1].valid |-> (cell_entry[0].valid &&
                               cell_entry[0].total >= cell_entry[1].total))
      else $error("record_sort_by_total_score: chain out of order");

endmodule
